### rtl/pjc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjc_pkg
// Shared constants, types and helpers of the planar joint constraint unit.
// ----------------------------------------------------------------------------
package pjc_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int TRIG_ITERATIONS = 24;
    localparam int TRIG_Q          = 28;
    localparam int TRIG_LAT        = TRIG_ITERATIONS + 5;

    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [63:0] CQ             = INV_TWO_PI_Q64 >> FRAC_BITS;
    localparam logic [31:0] CQ_LO          = CQ[31:0];
    localparam logic [31:0] CQ_HI          = CQ[63:32];

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [31:0] PIHALF_Q30   = 32'sd1686629713;

    localparam logic signed [47:0] ONE_V = 48'sd1 <<< FRAC_BITS;

    localparam logic [2:0] SLOT_RES  = 3'd0;
    localparam logic [2:0] SLOT_B0   = 3'd4;
    localparam logic [2:0] SLOT_LAST = 3'd6;

    typedef logic signed [31:0] word_t;
    typedef logic signed [47:0] wide_t;

    typedef struct packed {
        logic  prism;
        logic  ground;
        word_t ax;
        word_t ay;
        word_t aa;
        word_t bx;
        word_t by;
        word_t ba;
        word_t sax;
        word_t say;
        word_t sbx;
        word_t sby;
    } base_t;

    typedef struct packed {
        logic  prism;
        logic  ground;
        wide_t res_x;
        wide_t res_y;
        wide_t adiff;
        word_t ux;
        word_t uy;
        wide_t wx;
        wide_t wy;
    } geo_t;

    typedef struct packed {
        logic              ground;
        logic [6:0][31:0]  first;
        logic [6:0][31:0]  second;
    } bundle_t;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] v;
        case (i)
            0:  v = 34'sh3243F6A8;
            1:  v = 34'sh1DAC6705;
            2:  v = 34'sh0FADBAFC;
            3:  v = 34'sh07F56EA6;
            4:  v = 34'sh03FEAB76;
            5:  v = 34'sh01FFD55B;
            6:  v = 34'sh00FFFAAA;
            7:  v = 34'sh007FFF55;
            8:  v = 34'sh003FFFEA;
            9:  v = 34'sh001FFFFD;
            10: v = 34'sh000FFFFF;
            11: v = 34'sh0007FFFF;
            12: v = 34'sh0003FFFF;
            13: v = 34'sh0001FFFF;
            14: v = 34'sh0000FFFF;
            15: v = 34'sh00007FFF;
            16: v = 34'sh00003FFF;
            17: v = 34'sh00001FFF;
            18: v = 34'sh00000FFF;
            19: v = 34'sh000007FF;
            20: v = 34'sh000003FF;
            21: v = 34'sh000001FF;
            22: v = 34'sh000000FF;
            23: v = 34'sh0000007F;
            24: v = 34'sh0000003F;
            25: v = 34'sh0000001F;
            26: v = 34'sh0000000F;
            27: v = 34'sh00000008;
            28: v = 34'sh00000004;
            29: v = 34'sh00000002;
            default: v = 34'sh00000001;
        endcase
        return v;
    endfunction

    function automatic word_t sat32(input wide_t v);
        word_t r;
        if (v > 48'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -48'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Q28 trig term to the data fraction, round half up
    function automatic wide_t to_frac(input word_t t);
        wide_t e;
        wide_t r;
        e = 48'(t);
        if (TRIG_Q == FRAC_BITS)
            r = e;
        else
            r = (e + (48'sd1 <<< (TRIG_Q - FRAC_BITS - 1))) >>> (TRIG_Q - FRAC_BITS);
        return r;
    endfunction

endpackage

### rtl/pjc_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjc_sincos
// Pipelined angle reduction and rotation CORDIC, cosine and sine in Q28.
// ----------------------------------------------------------------------------
module pjc_sincos
    import pjc_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t angle,
    output word_t cos_q28,
    output word_t sin_q28
);

    localparam int RSH = 30 - TRIG_Q;

    logic [31:0]        hi_reg;
    logic [31:0]        lo_reg;
    logic [1:0]         quad_a_reg;
    logic signed [31:0] r_reg;
    logic [1:0]         quad_b_reg;
    logic signed [63:0] zp_reg;
    logic signed [33:0] x_reg [0:TRIG_ITERATIONS];
    logic signed [33:0] y_reg [0:TRIG_ITERATIONS];
    logic signed [33:0] z_reg [0:TRIG_ITERATIONS];
    logic [1:0]         q_reg [0:TRIG_ITERATIONS];
    word_t              cos_reg;
    word_t              sin_reg;

    logic signed [64:0] p_lo;
    logic signed [64:0] p_hi;
    logic [31:0]        turns;
    logic [31:0]        turns_h;
    logic [1:0]         quad;
    logic signed [63:0] z_round;
    logic signed [33:0] xr;
    logic signed [33:0] yr;

    assign p_lo    = $signed(angle) * $signed({1'b0, CQ_LO});
    assign p_hi    = $signed(angle) * $signed({1'b0, CQ_HI});
    assign turns   = hi_reg + lo_reg;
    assign turns_h = turns + 32'h2000_0000;
    assign quad    = turns_h[31:30];
    assign z_round = (zp_reg + (64'sd1 <<< 29)) >>> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg     <= p_hi[31:0];
            lo_reg     <= p_lo[63:32];
            quad_a_reg <= quad;
            r_reg      <= $signed(turns - {quad, 30'b0});
            quad_b_reg <= quad_a_reg;
            zp_reg     <= r_reg * PIHALF_Q30;
            x_reg[0]   <= CORDIC_START;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_round[33:0];
            q_reg[0]   <= quad_b_reg;
        end
    end

    for (genvar i = 0; i < TRIG_ITERATIONS; i++)
    begin : g_iter
        localparam logic signed [33:0] ATAN = atan_q30(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    assign xr = (x_reg[TRIG_ITERATIONS] + (34'sd1 <<< (RSH - 1))) >>> RSH;
    assign yr = (y_reg[TRIG_ITERATIONS] + (34'sd1 <<< (RSH - 1))) >>> RSH;

    // fold the quadrant back in
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (q_reg[TRIG_ITERATIONS])
                2'd0:
                begin
                    cos_reg <= xr[31:0];
                    sin_reg <= yr[31:0];
                end
                2'd1:
                begin
                    cos_reg <= -yr[31:0];
                    sin_reg <= xr[31:0];
                end
                2'd2:
                begin
                    cos_reg <= -xr[31:0];
                    sin_reg <= -yr[31:0];
                end
                default:
                begin
                    cos_reg <= yr[31:0];
                    sin_reg <= -xr[31:0];
                end
            endcase
        end
    end

    assign cos_q28 = cos_reg;
    assign sin_q28 = sin_reg;

endmodule

### rtl/pjc_wmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjc_wmul
// Two-stage 40 by 32 bit product, rounded half up from Q28 to the data scale.
// ----------------------------------------------------------------------------
module pjc_wmul
    import pjc_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [39:0] a,
    input  word_t              t,
    output wide_t              p
);

    logic signed [52:0] lo_reg;
    logic signed [51:0] hi_reg;
    wide_t              p_reg;
    logic signed [71:0] sum;
    logic signed [71:0] sh;

    assign sum = (72'(hi_reg) <<< 20) + 72'(lo_reg) + (72'sd1 <<< (TRIG_Q - 1));
    assign sh  = sum >>> TRIG_Q;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= $signed({1'b0, a[19:0]}) * t;
            hi_reg <= $signed(a[39:20]) * t;
            p_reg  <= sh[47:0];
        end
    end

    assign p = p_reg;

endmodule

### rtl/pjc_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjc_emit
// Result sequencer: plays one joint's bundle out, one beat per cycle.
// ----------------------------------------------------------------------------
module pjc_emit
    import pjc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  bundle_t     in_bundle,
    output logic        take,
    output logic        result_valid,
    output logic        kind,
    output logic [2:0]  row,
    output word_t       first_value,
    output word_t       second_value,
    output logic        last
);

    logic       act_reg;
    logic [2:0] cnt_reg;
    bundle_t    bun_reg;

    assign take = !act_reg || (cnt_reg == SLOT_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            cnt_reg <= SLOT_RES;
        end
        else if (take && in_valid)
        begin
            act_reg <= 1'b1;
            cnt_reg <= SLOT_RES;
        end
        else if (act_reg)
        begin
            if (cnt_reg == SLOT_LAST)
                act_reg <= 1'b0;
            else if (cnt_reg == SLOT_RES && bun_reg.ground)
                cnt_reg <= SLOT_B0;
            else
                cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
            bun_reg <= in_bundle;
    end

    assign result_valid = act_reg;
    assign kind         = (cnt_reg != SLOT_RES);
    assign row          = (cnt_reg == SLOT_RES) ? 3'd0 :
                          bun_reg.ground ? (cnt_reg - SLOT_B0) : (cnt_reg - 3'd1);
    assign first_value  = bun_reg.first[cnt_reg];
    assign second_value = bun_reg.second[cnt_reg];
    assign last         = (cnt_reg == SLOT_LAST);

endmodule

### rtl/planar_joint_constraint_eval_top.sv
`timescale 1ns / 1ps
// The single result port limits throughput: each joint plays out its residual beat and its rows
// there (only the B rows with ground body A); the pipeline accepts a joint every cycle while that
// port is free.
// busy is high while a finished joint in the last stage waits for the sequencer.
// Reset (rst_n low) clears all valid bits and the sequencer; no results follow.
// ----------------------------------------------------------------------------
// planar_joint_constraint_eval_top
// Revolute or prismatic joint residuals and transposed Jacobian rows.
// ----------------------------------------------------------------------------
module planar_joint_constraint_eval_top
    import pjc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        joint_mode,
    input  logic        a_is_ground,
    input  word_t       a_pos_x,
    input  word_t       a_pos_y,
    input  word_t       a_angle,
    input  word_t       b_pos_x,
    input  word_t       b_pos_y,
    input  word_t       b_angle,
    input  word_t       a_offset_x,
    input  word_t       a_offset_y,
    input  word_t       b_offset_x,
    input  word_t       b_offset_y,
    output logic        result_valid,
    output logic        kind,
    output logic [2:0]  row,
    output word_t       first_value,
    output word_t       second_value,
    output logic        last
);

    logic    en;
    logic    take;
    logic    accept;

    logic    v0_reg;
    base_t   s0_reg;
    logic    dv_reg [TRIG_LAT];
    base_t   d_reg  [TRIG_LAT];
    logic    ev_reg [2];
    base_t   e_reg  [2];
    word_t   ux_reg [2];
    word_t   uy_reg [2];
    logic    pv_reg;
    base_t   p_reg;
    word_t   pux_reg;
    word_t   puy_reg;
    wide_t   wx_reg;
    wide_t   wy_reg;
    wide_t   vx_reg;
    wide_t   vy_reg;
    logic    qv_reg;
    geo_t    q_reg;
    wide_t   dx_reg;
    wide_t   dy_reg;
    wide_t   ex_reg;
    wide_t   ey_reg;
    logic    fv_reg [2];
    geo_t    f_reg  [2];
    logic    rv_reg;
    bundle_t r_reg;

    word_t   ca;
    word_t   sa;
    word_t   cb;
    word_t   sb;
    wide_t   m1 [8];
    wide_t   m2 [6];
    base_t   s0_next;
    bundle_t r_next;
    base_t   dl;

    assign en     = !(rv_reg && !take);
    assign busy   = !en;
    assign accept = start && en;
    assign dl     = d_reg[TRIG_LAT-1];

    // ground body A: pose and offset read as zero
    always_comb
    begin
        s0_next.prism  = joint_mode;
        s0_next.ground = a_is_ground;
        s0_next.ax     = a_is_ground ? '0 : a_pos_x;
        s0_next.ay     = a_is_ground ? '0 : a_pos_y;
        s0_next.aa     = a_is_ground ? '0 : a_angle;
        s0_next.bx     = b_pos_x;
        s0_next.by     = b_pos_y;
        s0_next.ba     = b_angle;
        s0_next.sax    = a_is_ground ? '0 : a_offset_x;
        s0_next.say    = a_is_ground ? '0 : a_offset_y;
        s0_next.sbx    = b_offset_x;
        s0_next.sby    = b_offset_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int i = 0; i < TRIG_LAT; i++)
                dv_reg[i] <= 1'b0;
            ev_reg[0] <= 1'b0;
            ev_reg[1] <= 1'b0;
            pv_reg    <= 1'b0;
            qv_reg    <= 1'b0;
            fv_reg[0] <= 1'b0;
            fv_reg[1] <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= accept;
            dv_reg[0] <= v0_reg;
            for (int i = 1; i < TRIG_LAT; i++)
                dv_reg[i] <= dv_reg[i-1];
            ev_reg[0] <= dv_reg[TRIG_LAT-1];
            ev_reg[1] <= ev_reg[0];
            pv_reg    <= ev_reg[1];
            qv_reg    <= pv_reg;
            fv_reg[0] <= qv_reg;
            fv_reg[1] <= fv_reg[0];
            rv_reg    <= fv_reg[1];
        end
    end

    pjc_sincos u_trig_a (.clk(clk), .en(en), .angle(s0_reg.aa), .cos_q28(ca), .sin_q28(sa));
    pjc_sincos u_trig_b (.clk(clk), .en(en), .angle(s0_reg.ba), .cos_q28(cb), .sin_q28(sb));

    pjc_wmul u_m10 (.clk(clk), .en(en), .a(40'(dl.sax)), .t(ca), .p(m1[0]));
    pjc_wmul u_m11 (.clk(clk), .en(en), .a(40'(dl.say)), .t(sa), .p(m1[1]));
    pjc_wmul u_m12 (.clk(clk), .en(en), .a(40'(dl.sax)), .t(sa), .p(m1[2]));
    pjc_wmul u_m13 (.clk(clk), .en(en), .a(40'(dl.say)), .t(ca), .p(m1[3]));
    pjc_wmul u_m14 (.clk(clk), .en(en), .a(40'(dl.sbx)), .t(cb), .p(m1[4]));
    pjc_wmul u_m15 (.clk(clk), .en(en), .a(40'(dl.sby)), .t(sb), .p(m1[5]));
    pjc_wmul u_m16 (.clk(clk), .en(en), .a(40'(dl.sbx)), .t(sb), .p(m1[6]));
    pjc_wmul u_m17 (.clk(clk), .en(en), .a(40'(dl.sby)), .t(cb), .p(m1[7]));

    pjc_wmul u_m20 (.clk(clk), .en(en), .a(dx_reg[39:0]), .t(q_reg.ux), .p(m2[0]));
    pjc_wmul u_m21 (.clk(clk), .en(en), .a(dy_reg[39:0]), .t(q_reg.uy), .p(m2[1]));
    pjc_wmul u_m22 (.clk(clk), .en(en), .a(q_reg.wy[39:0]), .t(q_reg.ux), .p(m2[2]));
    pjc_wmul u_m23 (.clk(clk), .en(en), .a(q_reg.wx[39:0]), .t(q_reg.uy), .p(m2[3]));
    pjc_wmul u_m24 (.clk(clk), .en(en), .a(ey_reg[39:0]), .t(q_reg.ux), .p(m2[4]));
    pjc_wmul u_m25 (.clk(clk), .en(en), .a(ex_reg[39:0]), .t(q_reg.uy), .p(m2[5]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg   <= s0_next;
            d_reg[0] <= s0_reg;
            for (int i = 1; i < TRIG_LAT; i++)
                d_reg[i] <= d_reg[i-1];
            e_reg[0]  <= dl;
            e_reg[1]  <= e_reg[0];
            ux_reg[0] <= -sb;
            ux_reg[1] <= ux_reg[0];
            uy_reg[0] <= cb;
            uy_reg[1] <= uy_reg[0];

            p_reg   <= e_reg[1];
            pux_reg <= ux_reg[1];
            puy_reg <= uy_reg[1];
            wx_reg  <= m1[0] - m1[1];
            wy_reg  <= m1[2] + m1[3];
            vx_reg  <= m1[4] - m1[5];
            vy_reg  <= m1[6] + m1[7];

            q_reg.prism  <= p_reg.prism;
            q_reg.ground <= p_reg.ground;
            q_reg.res_x  <= 48'(p_reg.ax) + wx_reg - 48'(p_reg.bx);
            q_reg.res_y  <= 48'(p_reg.ay) + wy_reg - 48'(p_reg.by);
            q_reg.adiff  <= 48'(p_reg.aa) - 48'(p_reg.ba);
            q_reg.ux     <= pux_reg;
            q_reg.uy     <= puy_reg;
            q_reg.wx     <= wx_reg;
            q_reg.wy     <= wy_reg;
            dx_reg <= 48'(p_reg.bx) + vx_reg - 48'(p_reg.ax) - wx_reg;
            dy_reg <= 48'(p_reg.by) + vy_reg - 48'(p_reg.ay) - wy_reg;
            ex_reg <= 48'(p_reg.bx) - 48'(p_reg.ax) - wx_reg;
            ey_reg <= 48'(p_reg.by) - 48'(p_reg.ay) - wy_reg;

            f_reg[0] <= q_reg;
            f_reg[1] <= f_reg[0];
            r_reg    <= r_next;
        end
    end

    // slots: residual, three A rows, three B rows
    always_comb
    begin
        r_next.ground = f_reg[1].ground;
        if (f_reg[1].prism)
        begin
            r_next.first[0]  = sat32(m2[0] + m2[1]);
            r_next.second[0] = sat32(f_reg[1].adiff);
            r_next.first[1]  = sat32(-to_frac(f_reg[1].ux));
            r_next.second[1] = '0;
            r_next.first[2]  = sat32(-to_frac(f_reg[1].uy));
            r_next.second[2] = '0;
            r_next.first[3]  = sat32(m2[2] - m2[3]);
            r_next.second[3] = sat32(ONE_V);
            r_next.first[4]  = sat32(to_frac(f_reg[1].ux));
            r_next.second[4] = '0;
            r_next.first[5]  = sat32(to_frac(f_reg[1].uy));
            r_next.second[5] = '0;
            r_next.first[6]  = sat32(m2[4] - m2[5]);
            r_next.second[6] = sat32(-ONE_V);
        end
        else
        begin
            r_next.first[0]  = sat32(f_reg[1].res_x);
            r_next.second[0] = sat32(f_reg[1].res_y);
            r_next.first[1]  = sat32(ONE_V);
            r_next.second[1] = '0;
            r_next.first[2]  = '0;
            r_next.second[2] = sat32(ONE_V);
            r_next.first[3]  = sat32(-f_reg[1].wy);
            r_next.second[3] = sat32(f_reg[1].wx);
            r_next.first[4]  = sat32(-ONE_V);
            r_next.second[4] = '0;
            r_next.first[5]  = '0;
            r_next.second[5] = sat32(-ONE_V);
            r_next.first[6]  = '0;
            r_next.second[6] = '0;
        end
    end

    pjc_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (rv_reg),
        .in_bundle    (r_reg),
        .take         (take),
        .result_valid (result_valid),
        .kind         (kind),
        .row          (row),
        .first_value  (first_value),
        .second_value (second_value),
        .last         (last)
    );

`ifndef SYNTH
    a_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("result beats of one joint not contiguous");
    a_res_first: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid || !kind)
        else $error("joint does not open with its residual beat");
    a_res_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !kind |-> row == 3'd0 && !last)
        else $error("residual beat with row or last set");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> rv_reg && $stable(r_reg))
        else $error("finished joint lost while held");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the planar joint constraint unit: directed and random joints are
// sent under varying sender gaps, and each result beat is compared with a
// fixed-point prediction of the residuals and transposed Jacobian rows.
// ----------------------------------------------------------------------------
module tb_top
    import pjc_pkg::*;
();

    typedef struct {
        logic  prism;
        logic  ground;
        word_t ax, ay, aa, bx, by, ba, sax, say, sbx, sby;
    } joint_t;

    typedef struct {
        logic        kind;
        logic [2:0]  row;
        logic [31:0] v0;
        logic [31:0] v1;
        logic        last;
    } beat_t;

    localparam int TQ = 28;
    localparam int FB = 16;

    class joint_scoreboard;
        beat_t pending[$];
        int    errors = 0;

        function longint rnd(longint v, int s);
            if (s == 0)
                return v;
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint mul_t(longint a, longint t);
            return rnd(a * t, TQ);
        endfunction

        function logic [31:0] sat(longint v);
            if (v > 64'sd2147483647)
                return 32'h7FFFFFFF;
            if (v < -64'sd2147483648)
                return 32'h80000000;
            return v[31:0];
        endfunction

        function void sincos(longint angle, output longint c, output longint s);
            longint atab[24] = '{
                'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
                'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
                'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
                'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
            logic [63:0] cq;
            logic [63:0] prod;
            logic [31:0] turns;
            logic [31:0] ru;
            logic [1:0]  quad;
            longint r, z, x, y, nx;
            cq    = 64'h28BE60DB9391054A >> FB;
            prod  = angle * cq;
            turns = prod[63:32];
            quad  = 2'((turns + 32'h20000000) >> 30);
            ru    = turns - (32'(quad) << 30);
            r     = longint'(signed'(ru));
            z     = rnd(r * 64'sd1686629713, 30);
            x     = 652032874;
            y     = 0;
            for (int i = 0; i < 24; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i); y = y + (x >>> i); z -= atab[i];
                end
                else
                begin
                    nx = x + (y >>> i); y = y - (x >>> i); z += atab[i];
                end
                x = nx;
            end
            x = rnd(x, 30 - TQ);
            y = rnd(y, 30 - TQ);
            case (quad)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void add(logic k, int row, longint v0, longint v1, logic lst);
            beat_t b;
            b.kind = k; b.row = 3'(row); b.v0 = sat(v0); b.v1 = sat(v1); b.last = lst;
            pending.push_back(b);
        endfunction

        function void note_joint(joint_t j);
            longint ax, ay, aa, bx, by, ba, sax, say, sbx, sby;
            longint ca, sa, cb, sb, wx, wy, ux, uy, vx, vy, dx, dy, ex, ey, one;
            int     base;
            ax = j.ax; ay = j.ay; aa = j.aa; bx = j.bx; by = j.by; ba = j.ba;
            sax = j.sax; say = j.say; sbx = j.sbx; sby = j.sby;
            one  = 64'sd1 <<< FB;
            base = j.ground ? 0 : 3;
            if (j.ground)
            begin
                ax = 0; ay = 0; aa = 0; sax = 0; say = 0;
            end
            sincos(aa, ca, sa);
            sincos(ba, cb, sb);
            wx = mul_t(sax, ca) - mul_t(say, sa);
            wy = mul_t(sax, sa) + mul_t(say, ca);
            ux = -sb;
            uy = cb;
            if (j.prism)
            begin
                vx = mul_t(sbx, cb) - mul_t(sby, sb);
                vy = mul_t(sbx, sb) + mul_t(sby, cb);
                dx = bx + vx - ax - wx; dy = by + vy - ay - wy;
                ex = bx - ax - wx;      ey = by - ay - wy;
                add(0, 0, mul_t(dx, ux) + mul_t(dy, uy), aa - ba, 0);
                if (!j.ground)
                begin
                    add(1, 0, -rnd(ux, TQ - FB), 0, 0);
                    add(1, 1, -rnd(uy, TQ - FB), 0, 0);
                    add(1, 2, mul_t(wy, ux) - mul_t(wx, uy), one, 0);
                end
                add(1, base, rnd(ux, TQ - FB), 0, 0);
                add(1, base + 1, rnd(uy, TQ - FB), 0, 0);
                add(1, base + 2, mul_t(ey, ux) - mul_t(ex, uy), -one, 1);
            end
            else
            begin
                add(0, 0, ax + wx - bx, ay + wy - by, 0);
                if (!j.ground)
                begin
                    add(1, 0, one, 0, 0);
                    add(1, 1, 0, one, 0);
                    add(1, 2, -wy, wx, 0);
                end
                add(1, base, -one, 0, 0);
                add(1, base + 1, 0, -one, 0);
                add(1, base + 2, 0, 0, 1);
            end
        endfunction

        function void check_beat(beat_t got);
            beat_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat kind=%0d row=%0d", got.kind, got.row);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.kind)
            begin
                $error("kind: expected %0d, got %0d", e.kind, got.kind); errors++;
            end
            if (got.row !== e.row)
            begin
                $error("row: expected %0d, got %0d", e.row, got.row); errors++;
            end
            if (got.v0 !== e.v0)
            begin
                $error("first_value: expected %0d, got %0d",
                       signed'(e.v0), signed'(got.v0)); errors++;
            end
            if (got.v1 !== e.v1)
            begin
                $error("second_value: expected %0d, got %0d",
                       signed'(e.v1), signed'(got.v1)); errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        joint_mode = 1'b0;
    logic        a_is_ground = 1'b0;
    word_t       a_pos_x = '0, a_pos_y = '0, a_angle = '0;
    word_t       b_pos_x = '0, b_pos_y = '0, b_angle = '0;
    word_t       a_offset_x = '0, a_offset_y = '0, b_offset_x = '0, b_offset_y = '0;
    logic        result_valid;
    logic        kind;
    logic [2:0]  row;
    word_t       first_value, second_value;
    logic        last;

    joint_scoreboard sb = new();
    int          gap_pct = 0;
    longint      cycles = 0;

    planar_joint_constraint_eval_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .joint_mode(joint_mode), .a_is_ground(a_is_ground),
        .a_pos_x(a_pos_x), .a_pos_y(a_pos_y), .a_angle(a_angle),
        .b_pos_x(b_pos_x), .b_pos_y(b_pos_y), .b_angle(b_angle),
        .a_offset_x(a_offset_x), .a_offset_y(a_offset_y),
        .b_offset_x(b_offset_x), .b_offset_y(b_offset_y),
        .result_valid(result_valid), .kind(kind), .row(row),
        .first_value(first_value), .second_value(second_value), .last(last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // note each accepted joint and check each result beat
    always @(posedge clk)
    begin
        joint_t j;
        beat_t  b;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                j.prism = joint_mode; j.ground = a_is_ground;
                j.ax = a_pos_x; j.ay = a_pos_y; j.aa = a_angle;
                j.bx = b_pos_x; j.by = b_pos_y; j.ba = b_angle;
                j.sax = a_offset_x; j.say = a_offset_y;
                j.sbx = b_offset_x; j.sby = b_offset_y;
                sb.note_joint(j);
            end
            if (result_valid)
            begin
                b.kind = kind; b.row = row; b.v0 = first_value;
                b.v1 = second_value; b.last = last;
                sb.check_beat(b);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_joint(joint_t j);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        joint_mode <= j.prism; a_is_ground <= j.ground;
        a_pos_x <= j.ax; a_pos_y <= j.ay; a_angle <= j.aa;
        b_pos_x <= j.bx; b_pos_y <= j.by; b_angle <= j.ba;
        a_offset_x <= j.sax; a_offset_y <= j.say;
        b_offset_x <= j.sbx; b_offset_y <= j.sby;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic word_t pick(int mode);
        case ($urandom_range(mode ? 5 : 3))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(200000)) - 100000);
            2: return 32'(signed'($urandom_range(13000000)) - 6500000);
            3: return 32'sh7FFFFFFF ^ 32'($urandom_range(1) << 31);
            default: return 32'(signed'($urandom_range(40000)) - 20000);
        endcase
    endfunction

    function automatic joint_t rand_joint();
        joint_t j;
        int     m;
        m = $urandom_range(2);
        j.prism = 1'($urandom_range(1)); j.ground = 1'($urandom_range(1));
        j.ax = pick(m); j.ay = pick(m); j.aa = pick(m);
        j.bx = pick(m); j.by = pick(m); j.ba = pick(m);
        j.sax = pick(m); j.say = pick(m); j.sbx = pick(m); j.sby = pick(m);
        return j;
    endfunction

    function automatic joint_t fill(logic p, logic g, word_t v, word_t ang);
        joint_t j;
        j.prism = p; j.ground = g;
        j.ax = v; j.ay = -v; j.aa = ang; j.bx = -v; j.by = v; j.ba = -ang;
        j.sax = v; j.say = v; j.sbx = -v; j.sby = v;
        return j;
    endfunction

    initial
    begin
        word_t vals[5]   = '{32'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd65536, -32'sd3};
        word_t angles[5] = '{32'sd0, 32'sd102944, -32'sd205887, 32'sh7FFFFFFF, 32'sh80000000};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: each joint kind with and without ground, extreme values and angles
        for (int t = 0; t < 4; t++)
            for (int k = 0; k < 5; k++)
                send_joint(fill(t[0], t[1], vals[k], angles[k]));
        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 19 : (phase == 1) ? 62 : 0;
            repeat (170) send_joint(rand_joint());
        end
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
